// ----- design/dtq_pkg.sv -----
// shared types and constants for the deadline timer queue
package dtq_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = 4;
  localparam int TIME_BITS = 48;
  localparam int PER_W     = 32;
  localparam int CNT_W     = 5;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_POLL   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // one accepted command, held in the front queue
  typedef struct packed {
    logic [1:0]           mode;
    logic [TIME_BITS-1:0] now_ms;
    logic [PER_W-1:0]     period_ms;
    logic                 recurring;
    logic [SLOT_W-1:0]    slot_sel;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [SLOT_W-1:0]    slot_out;
    logic [1:0]           status;
    logic                 expired_valid;
    logic                 last;
    logic                 new_earliest;
    logic                 any_pending;
    logic [TIME_BITS-1:0] time_to_next;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT,
    S_FIN,
    S_OUT
  } eng_state_t;

endpackage

// ----- design/deadline_timer_queue_top.sv -----
// top level: input front, command queue and execution engine
// Each item is taken into a two-entry queue and then carried out by a
// sequencer that walks the sixteen slots one per cycle. Add, cancel and the
// unused mode run one slot scan that finds the earliest deadline for
// time_to_next. A poll repeats the scan once per expired timer (deadline
// order, ties to the lower slot), then once more to find that nothing is
// left, then a closing scan, and sends one result per cycle while the
// receiver is ready. Every result of an item carries the table as it stands
// after the whole item. A stalled receiver holds the engine; the queue takes
// up to two more items before in_tready drops.
module deadline_timer_queue_top import dtq_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [87:0]   in_tdata,  // mode, now_ms, period_ms, recurring, slot_sel, pad
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata, // slot_out, status, any_pending, time_to_next, pad
  output logic [1:0]    out_tuser, // expired_valid, new_earliest
  output logic          out_tlast
);

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  res_t r;

  // front: unpack the item
  always_comb begin
    in_cmd.mode      = in_tdata[1:0];
    in_cmd.now_ms    = in_tdata[49:2];
    in_cmd.period_ms = in_tdata[81:50];
    in_cmd.recurring = in_tdata[82];
    in_cmd.slot_sel  = in_tdata[86:83];
  end

  dtq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (in_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  dtq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (r)
  );

  // pack the result item
  assign out_tdata = {9'd0, r.time_to_next, r.any_pending, r.status, r.slot_out};
  assign out_tuser = {r.new_earliest, r.expired_valid};
  assign out_tlast = r.last;

endmodule

// ----- design/dtq_fifo.sv -----
// two-entry command queue between the front and the engine
module dtq_fifo import dtq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ----- design/dtq_engine.sv -----
// slot table and the sequencer that carries out one command at a time
module dtq_engine import dtq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  eng_state_t state_r, state_nxt;

  logic [TIME_BITS-1:0] dl_r  [SLOTS];
  logic [PER_W-1:0]     per_r [SLOTS];
  logic [SLOTS-1:0]     rep_r;
  logic [SLOTS-1:0]     armed_r;
  logic [SLOTS-1:0]     taken_r;
  logic [SLOT_W-1:0]    ord_r [SLOTS];

  cmd_t                 cmd_r;
  logic [SLOT_W-1:0]    idx_r;
  logic                 best_v_r;
  logic [SLOT_W-1:0]    best_r;
  logic [TIME_BITS-1:0] best_dl_r;
  logic [CNT_W-1:0]     nexp_r;
  logic [SLOT_W-1:0]    em_r;
  logic                 added_r;
  logic [SLOT_W-1:0]    added_slot_r;
  logic                 scan_poll_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [1:0]           status_r;
  logic                 ne_r;
  logic                 pend_r;
  logic [TIME_BITS-1:0] ttn_r;

  logic                 cand;
  logic                 better;
  logic                 free_v;
  logic [SLOT_W-1:0]    free_idx;
  logic                 idx_end;
  logic                 is_poll;
  logic                 res_last;

  // lowest free slot, priority pick over sixteen flags
  always_comb begin
    free_v   = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!armed_r[i]) begin
        free_v   = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // one slot examined per scan cycle
  always_comb begin
    cand = armed_r[idx_r] && !taken_r[idx_r] &&
           (!scan_poll_r || (dl_r[idx_r] < cmd_r.now_ms));
    better = cand && (!best_v_r || (dl_r[idx_r] < best_dl_r));
  end

  assign idx_end = (idx_r == SLOT_W'(SLOTS - 1));
  assign is_poll = (cmd_r.mode == MODE_POLL);

  // result item under the emit index, summary shared by every result
  always_comb begin
    res              = '0;
    res.any_pending  = pend_r;
    res.time_to_next = ttn_r;
    if (is_poll && nexp_r != '0) begin
      res.slot_out      = ord_r[em_r];
      res.expired_valid = 1'b1;
      res.last          = (CNT_W'(em_r) + CNT_W'(1) == nexp_r);
    end else begin
      res.slot_out     = slot_r;
      res.status       = status_r;
      res.new_earliest = ne_r;
      res.last         = 1'b1;
    end
  end

  assign res_last = res.last;

  // handshake outputs
  always_comb begin
    cmd_ready = (state_r == S_IDLE);
    res_valid = (state_r == S_OUT);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (cmd_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_SCAN;
      S_SCAN: if (idx_end) state_nxt = scan_poll_r ? S_EMIT : S_FIN;
      S_EMIT: state_nxt = S_SCAN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (res_ready && res_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath and table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= '0;
      scan_poll_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) cmd_r <= cmd;
        end
        S_EXEC: begin
          taken_r     <= '0;
          nexp_r      <= '0;
          idx_r       <= '0;
          best_v_r    <= 1'b0;
          scan_poll_r <= (cmd_r.mode == MODE_POLL);
          case (cmd_r.mode)
            MODE_ADD: begin
              // free_idx is zero when the table is full
              slot_r       <= free_idx;
              status_r     <= free_v ? ST_OK : ST_FULL;
              added_r      <= free_v;
              added_slot_r <= free_idx;
              if (free_v) begin
                dl_r[free_idx]    <= cmd_r.now_ms + TIME_BITS'(cmd_r.period_ms);
                per_r[free_idx]   <= cmd_r.period_ms;
                rep_r[free_idx]   <= cmd_r.recurring;
                armed_r[free_idx] <= 1'b1;
              end
            end
            MODE_CANCEL: begin
              slot_r                  <= cmd_r.slot_sel;
              status_r                <= armed_r[cmd_r.slot_sel] ? ST_OK : ST_NOTFOUND;
              added_r                 <= 1'b0;
              armed_r[cmd_r.slot_sel] <= 1'b0;
            end
            default: begin
              slot_r   <= '0;
              status_r <= ST_OK;
              added_r  <= 1'b0;
            end
          endcase
        end
        S_SCAN: begin
          if (better) begin
            best_v_r  <= 1'b1;
            best_r    <= idx_r;
            best_dl_r <= dl_r[idx_r];
          end
          idx_r <= idx_r + SLOT_W'(1);
        end
        S_EMIT: begin
          idx_r    <= '0;
          best_v_r <= 1'b0;
          if (best_v_r) begin
            // earliest expired timer: record it and re-arm or disarm
            taken_r[best_r]              <= 1'b1;
            ord_r[nexp_r[SLOT_W-1:0]]    <= best_r;
            nexp_r                       <= nexp_r + CNT_W'(1);
            if (rep_r[best_r]) dl_r[best_r] <= cmd_r.now_ms + TIME_BITS'(per_r[best_r]);
            else armed_r[best_r] <= 1'b0;
          end else begin
            // nothing more expired: closing scan over every armed slot
            taken_r     <= '0;
            scan_poll_r <= 1'b0;
          end
        end
        S_FIN: begin
          // closing scan is done: earliest slot in best_r
          pend_r <= best_v_r;
          ne_r   <= added_r && best_v_r && (best_r == added_slot_r);
          em_r   <= '0;
          if (!best_v_r) ttn_r <= '1;
          else if (best_dl_r > cmd_r.now_ms) ttn_r <= best_dl_r - cmd_r.now_ms;
          else ttn_r <= '0;
        end
        S_OUT: begin
          if (res_ready && !res_last) em_r <= em_r + SLOT_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- design/dtq_checker.sv -----
// port-level checks on the timer queue, bound to the top level
module dtq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed under stall");

  // nothing pending means time_to_next all ones
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[6] |-> out_tdata[54:7] == 48'hFFFFFFFFFFFF)
    else $error("empty table with finite time");

  // an expired entry never also flags a new earliest
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("conflicting flags");

  // no result and a ready input straight out of reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("result after reset");

endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- test/deadline_timer_queue_top_tb.sv -----
// self-checking testbench for the deadline timer queue: directed and random commands
module deadline_timer_queue_top_tb;
  import dtq_pkg::*;

  // expected result as seen on the output channel
  typedef struct {
    logic [SLOT_W-1:0]    slot_out;
    logic [1:0]           status;
    logic                 expired_valid;
    logic                 last;
    logic                 new_earliest;
    logic                 any_pending;
    logic [TIME_BITS-1:0] time_to_next;
  } timer_res_t;

  // timer table mirror and expected result store
  class timer_scoreboard;
    logic [TIME_BITS-1:0] deadline [SLOTS];
    logic [PER_W-1:0]     period [SLOTS];
    logic                 repeat_en [SLOTS];
    logic                 armed [SLOTS];
    timer_res_t           pending_res [$];
    int                   errors;

    function new();
      for (int i = 0; i < SLOTS; i++) armed[i] = 1'b0;
      errors = 0;
    endfunction

    function int earliest();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
        if (armed[i] && (best < 0 || deadline[i] < deadline[best])) best = i;
      return best;
    endfunction

    // apply one accepted command to the table and queue its results
    function void note_command(cmd_t c);
      timer_res_t r;
      timer_res_t batch [$];
      int fs, e, best;
      bit taken [SLOTS];
      int order [$];
      r = '{default: '0};
      r.last = 1'b1;
      case (c.mode)
        MODE_ADD: begin
          fs = -1;
          for (int i = 0; i < SLOTS; i++)
            if (!armed[i] && fs < 0) fs = i;
          if (fs < 0) begin
            r.status = ST_FULL;
          end else begin
            deadline[fs] = c.now_ms + c.period_ms;
            period[fs] = c.period_ms;
            repeat_en[fs] = c.recurring;
            armed[fs] = 1'b1;
            r.slot_out = fs[SLOT_W-1:0];
            r.new_earliest = (earliest() == fs);
          end
          batch = {batch, r};
        end
        MODE_CANCEL: begin
          r.slot_out = c.slot_sel;
          if (armed[c.slot_sel]) armed[c.slot_sel] = 1'b0;
          else r.status = ST_NOTFOUND;
          batch = {batch, r};
        end
        MODE_POLL: begin
          for (int i = 0; i < SLOTS; i++) taken[i] = 1'b0;
          forever begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
              if (armed[i] && !taken[i] && deadline[i] < c.now_ms &&
                  (best < 0 || deadline[i] < deadline[best])) best = i;
            if (best < 0) break;
            taken[best] = 1'b1;
            order = {order, best};
          end
          foreach (order[k]) armed[order[k]] = 1'b0;
          foreach (order[k]) begin
            if (repeat_en[order[k]]) begin
              deadline[order[k]] = c.now_ms + period[order[k]];
              armed[order[k]] = 1'b1;
            end
            r.slot_out = order[k][SLOT_W-1:0];
            r.expired_valid = 1'b1;
            r.last = (k == order.size() - 1);
            batch = {batch, r};
          end
          if (order.size() == 0) batch = {batch, r};
        end
        default: batch = {batch, r};
      endcase
      e = earliest();
      foreach (batch[k]) begin
        batch[k].any_pending = (e >= 0);
        if (e < 0) batch[k].time_to_next = '1;
        else batch[k].time_to_next = (deadline[e] > c.now_ms) ? deadline[e] - c.now_ms : '0;
        pending_res = {pending_res, batch[k]};
      end
    endfunction

    function void check_result(logic [63:0] d, logic [1:0] u, logic tl);
      timer_res_t x;
      if (pending_res.size() == 0) begin
        $error("unexpected result item 0x%h", d);
        errors++;
        return;
      end
      x = pending_res.pop_front();
      if (d[3:0] !== x.slot_out) begin
        $error("slot_out exp %0d got %0d", x.slot_out, d[3:0]); errors++;
      end
      if (d[5:4] !== x.status) begin
        $error("status exp %0d got %0d", x.status, d[5:4]); errors++;
      end
      if (d[6] !== x.any_pending) begin
        $error("any_pending exp %0d got %0d", x.any_pending, d[6]); errors++;
      end
      if (d[54:7] !== x.time_to_next) begin
        $error("time_to_next exp %0d got %0d", x.time_to_next, d[54:7]); errors++;
      end
      if (u[0] !== x.expired_valid) begin
        $error("expired_valid exp %0d got %0d", x.expired_valid, u[0]); errors++;
      end
      if (u[1] !== x.new_earliest) begin
        $error("new_earliest exp %0d got %0d", x.new_earliest, u[1]); errors++;
      end
      if (tl !== x.last) begin
        $error("last exp %0d got %0d", x.last, tl); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  timer_scoreboard sb = new();
  logic [TIME_BITS-1:0] clock_ms = '0;
  bit hold_off = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  deadline_timer_queue_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // result checking at the rising edge
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);

  // receiver back-pressure
  initial begin
    int g;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        g = 1 + gap_len();
        out_tready <= 1'b0;
        repeat (g) @(negedge clk);
        out_tready <= 1'b1;
        @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // offer one item; tvalid stays high unless a gap or a drain follows
  task automatic send_cmd(logic [1:0] m, logic [TIME_BITS-1:0] t, logic [PER_W-1:0] p,
                          logic rec, logic [SLOT_W-1:0] s, bit idle_gaps);
    cmd_t c;
    int g;
    c.mode = m; c.now_ms = t; c.period_ms = p; c.recurring = rec; c.slot_sel = s;
    if (idle_gaps && $urandom_range(0, 2) == 0) begin
      g = gap_len();
      if (g > 0) begin
        in_tvalid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
    in_tdata <= {1'b0, s, rec, p, t, m};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_command(c);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending_res.size() != 0) @(negedge clk);
  endtask

  // one random command around the running clock
  task automatic random_cmd(bit idle_gaps);
    logic [1:0] m;
    logic [PER_W-1:0] p;
    int r;
    r = $urandom_range(0, 99);
    clock_ms = clock_ms + $urandom_range(0, 60);
    if (r < 45) m = MODE_ADD;
    else if (r < 65) m = MODE_CANCEL;
    else if (r < 97) m = MODE_POLL;
    else m = 2'd3;
    case ($urandom_range(0, 9))
      0: p = $urandom();
      1: p = '0;
      default: p = $urandom_range(0, 120);
    endcase
    send_cmd(m, ($urandom_range(0, 19) == 0) ? TIME_BITS'({$urandom(), $urandom()}) : clock_ms,
             p, 1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, SLOTS - 1)), idle_gaps);
  endtask

  initial begin
    logic [TIME_BITS-1:0] tmax;
    tmax = '1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, fill to full, ties, wrap, cancels, big poll
    send_cmd(MODE_POLL, '0, '0, 1'b0, '0, 1'b0);
    send_cmd(MODE_CANCEL, '0, '0, 1'b0, 4'd15, 1'b0);
    send_cmd(2'd3, tmax, '1, 1'b1, 4'd15, 1'b0);
    send_cmd(MODE_ADD, 48'd100, 32'd0, 1'b1, '0, 1'b0);
    send_cmd(MODE_ADD, 48'd100, 32'd5, 1'b0, '0, 1'b0);
    send_cmd(MODE_ADD, 48'd100, 32'd5, 1'b1, '0, 1'b0);
    send_cmd(MODE_ADD, tmax, '1, 1'b0, '0, 1'b0);
    for (int i = 0; i < 12; i++)
      send_cmd(MODE_ADD, 48'd100, 32'd3 + i, i[0], '0, 1'b0);
    send_cmd(MODE_ADD, 48'd100, 32'd1, 1'b0, '0, 1'b0);
    send_cmd(MODE_CANCEL, 48'd101, '0, 1'b0, 4'd2, 1'b0);
    send_cmd(MODE_CANCEL, 48'd101, '0, 1'b0, 4'd2, 1'b0);
    send_cmd(MODE_POLL, tmax, '0, 1'b0, '0, 1'b0);
    send_cmd(MODE_POLL, 48'd200, '0, 1'b0, '0, 1'b0);
    drain();
    clock_ms = 48'd300;

    // receiver held off while commands keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++) random_cmd(1'b0);
    join
    drain();

    for (int i = 0; i < 310; i++) begin
      random_cmd(1'b1);
      if (i == 150) drain();
    end
    drain();
    repeat (400) @(negedge clk);
    if (sb.errors == 0 && sb.pending_res.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
